// ===== rtl/s2da_pkg.sv =====
// ----------------------------------------------------------------------------
// s2da_pkg
// Shared types, constants and a sizing function for the signed integer to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package s2da_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [5:0] ASCII_ZERO  = 6'd48;
  localparam logic [5:0] ASCII_MINUS = 6'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic shift;
  } cell_ctrl_t;

  // Decimal digits needed for the largest magnitude, 2**(w-1).
  function automatic int num_digits(input int w);
    longint unsigned lim;
    longint unsigned p;
    int n;
    lim = 64'd1 << (w - 1);
    p = 64'd10;
    n = 1;
    for (int i = 0; i < 20; i++) begin
      if (p <= lim) begin
        n = n + 1;
        p = p * 64'd10;
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/s2da_in_if.sv =====
// ----------------------------------------------------------------------------
// s2da_in_if
// Input stream: one signed integer per beat.
// ----------------------------------------------------------------------------
interface s2da_in_if #(
  parameter int DATA_WIDTH = s2da_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/s2da_out_if.sv =====
// ----------------------------------------------------------------------------
// s2da_out_if
// Output stream: one ASCII character per beat, last marks the end of a number.
// ----------------------------------------------------------------------------
interface s2da_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/s2da_cell.sv =====
// ----------------------------------------------------------------------------
// s2da_cell
// One BCD digit of the conversion chain: add-3 adjust and shift during
// conversion, plain digit shift toward the top during readout.
// ----------------------------------------------------------------------------
module s2da_cell (
  input  logic                  clk,
  input  s2da_pkg::cell_ctrl_t  ctrl,
  input  logic                  carry_in,
  input  logic [3:0]            digit_in,
  output logic                  carry_out,
  output logic [3:0]            digit
);

  logic [3:0] adj;

  assign adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      digit <= 4'd0;
    end else if (ctrl.conv) begin
      digit <= {adj[2:0], carry_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

// ===== rtl/s2da_row.sv =====
// ----------------------------------------------------------------------------
// s2da_row
// Chain of BCD digit cells; cell 0 is the least significant digit.
// ----------------------------------------------------------------------------
module s2da_row #(
  parameter int NDIG = 10
) (
  input  logic                 clk,
  input  s2da_pkg::cell_ctrl_t ctrl,
  input  logic                 bit_in,
  output logic [3:0]           top
);

  logic [NDIG-1:0]      carry;
  logic [NDIG-1:0][3:0] digits;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_first
      s2da_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (bit_in),
        .digit_in  (4'd0),
        .carry_out (carry[i]),
        .digit     (digits[i])
      );
    end else begin : g_next
      s2da_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i-1]),
        .digit_in  (digits[i-1]),
        .carry_out (carry[i]),
        .digit     (digits[i])
      );
    end
  end

  assign top = digits[NDIG-1];

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer into its decimal ASCII text, one character a beat.
// ----------------------------------------------------------------------------
// One number is taken at a time. It is accepted in ST_IDLE, then converted
// binary to BCD in ST_CONV (one magnitude bit enters the digit chain per
// cycle), given a minus sign in ST_SIGN if negative, and the NDIG digits of
// the chain are read out one digit a cycle from the top while the output is
// not stalled, leading zeros dropped. The output register holds the last
// character while the next number is accepted.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = s2da_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  s2da_in_if.sink      din,
  s2da_out_if.source   dout
);

  localparam int NDIG = s2da_pkg::num_digits(DATA_WIDTH);
  localparam int SW   = $clog2(DATA_WIDTH);
  localparam int RW   = $clog2(NDIG + 1);

  s2da_pkg::state_t     state, state_next;
  s2da_pkg::cell_ctrl_t ctrl;

  logic [DATA_WIDTH-1:0] raw;
  logic [DATA_WIDTH-1:0] mag_in;
  logic [DATA_WIDTH-1:0] mag, mag_next;
  logic                  neg, neg_next;
  logic [SW-1:0]         step, step_next;
  logic [RW-1:0]         rem, rem_next;
  logic                  started, started_next;
  logic [3:0]            top;

  logic                  out_valid, out_valid_next;
  logic [5:0]            out_char, out_char_next;
  logic                  out_last, out_last_next;
  logic                  slot_free;
  logic                  emit_now;

  assign raw    = din.value;
  assign mag_in = raw[DATA_WIDTH-1] ? (~raw) + {{(DATA_WIDTH-1){1'b0}}, 1'b1} : raw;

  assign slot_free = !out_valid || dout.ready;
  assign emit_now  = started || (top != 4'd0) || (rem == RW'(1));

  s2da_row #(.NDIG(NDIG)) u_row (
    .clk    (clk),
    .ctrl   (ctrl),
    .bit_in (mag[DATA_WIDTH-1]),
    .top    (top)
  );

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    neg_next       = neg;
    step_next      = step;
    rem_next       = rem;
    started_next   = started;
    out_valid_next = out_valid && !dout.ready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    ctrl           = '0;
    din.ready      = 1'b0;

    unique case (state)
      s2da_pkg::ST_IDLE: begin
        din.ready = 1'b1;
        if (din.valid) begin
          ctrl.load  = 1'b1;
          mag_next   = mag_in;
          neg_next   = raw[DATA_WIDTH-1];
          step_next  = '0;
          state_next = s2da_pkg::ST_CONV;
        end
      end
      s2da_pkg::ST_CONV: begin
        ctrl.conv = 1'b1;
        mag_next  = {mag[DATA_WIDTH-2:0], 1'b0};
        step_next = step + SW'(1);
        if (step == SW'(DATA_WIDTH - 1)) begin
          rem_next     = RW'(NDIG);
          started_next = 1'b0;
          state_next   = neg ? s2da_pkg::ST_SIGN : s2da_pkg::ST_EMIT;
        end
      end
      s2da_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = s2da_pkg::ASCII_MINUS;
          out_last_next  = 1'b0;
          state_next     = s2da_pkg::ST_EMIT;
        end
      end
      s2da_pkg::ST_EMIT: begin
        if (slot_free) begin
          ctrl.shift   = 1'b1;
          rem_next     = rem - RW'(1);
          started_next = started || emit_now;
          if (emit_now) begin
            out_valid_next = 1'b1;
            out_char_next  = s2da_pkg::ASCII_ZERO + {2'b00, top};
            out_last_next  = (rem == RW'(1));
          end
          if (rem == RW'(1)) begin
            state_next = s2da_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = s2da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= s2da_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag      <= mag_next;
    neg      <= neg_next;
    step     <= step_next;
    rem      <= rem_next;
    started  <= started_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign dout.valid     = out_valid;
  assign dout.character = out_char;
  assign dout.last      = out_last;

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == s2da_pkg::ST_CONV |-> step <= SW'(DATA_WIDTH - 1))
    else $error("conversion step counter out of range");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == s2da_pkg::ST_EMIT |-> rem != '0)
    else $error("digit readout entered with no digits left");

  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    state == s2da_pkg::ST_EMIT |-> top <= 4'd9)
    else $error("digit chain holds a non-decimal digit");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    state == s2da_pkg::ST_EMIT && slot_free && rem == RW'(1)
    |=> out_valid && out_last && state == s2da_pkg::ST_IDLE)
    else $error("final digit not flagged as last");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != s2da_pkg::ST_IDLE |-> !din.ready)
    else $error("input accepted while a conversion is in progress");

endmodule

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed 32-bit numbers into the converter and checks every character
// beat against text predicted in the testbench. A directed set covers zero,
// the extremes and the digit-count boundaries. A random set follows with
// random gaps on both sides, one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

  localparam int WIDTH = 32;

  typedef struct packed {
    logic [5:0] character;
    logic       last;
  } char_beat_t;

  class text_scoreboard;
    char_beat_t pending_text[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < 30) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_value(logic [WIDTH-1:0] v);
      logic [WIDTH:0] mag;
      logic [3:0]     digs[$];
      char_beat_t     b;
      logic           neg;
      neg = v[WIDTH-1];
      mag = neg ? ({(WIDTH+1){1'b0}} - {1'b1, v}) : {1'b0, v};
      do begin
        digs.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
        b.character = s2da_pkg::ASCII_MINUS;
        b.last = 1'b0;
        pending_text.push_back(b);
      end
      foreach (digs[i]) begin
        b.character = s2da_pkg::ASCII_ZERO + 6'(digs[i]);
        b.last = (i == digs.size() - 1);
        pending_text.push_back(b);
      end
    endfunction

    task check_char(logic [5:0] character, logic last);
      char_beat_t want;
      if (pending_text.size() == 0) begin
        report($sformatf("unexpected beat char=%0d last=%b", character, last));
      end else begin
        want = pending_text.pop_front();
        if (character !== want.character)
          report($sformatf("char got %0d want %0d", character, want.character));
        if (last !== want.last)
          report($sformatf("last got %b want %b (char %0d)", last, want.last,
                           want.character));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   hold_sink;
  bit   no_idle;

  s2da_in_if #(.DATA_WIDTH(WIDTH)) din_if ();
  s2da_out_if dout_if ();

  signed_int_to_decimal_ascii #(.DATA_WIDTH(WIDTH)) uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  text_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[signed_int_to_decimal_ascii] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && din_if.valid && din_if.ready) sb.note_value(din_if.value);
    if (!rst && dout_if.valid && dout_if.ready)
      sb.check_char(dout_if.character, dout_if.last);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 20);
    return $urandom_range(30, 90);
  endfunction

  initial begin : sink_ready
    dout_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        dout_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 60) begin
        dout_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        dout_if.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  task automatic send_value(input logic [WIDTH-1:0] v);
    if (!no_idle && $urandom_range(0, 99) >= 55) begin
      din_if.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.value <= v;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_text.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WIDTH-1:0] random_value();
    longint lim;
    longint v;
    int     k;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        k = $urandom_range(1, 10);
        lim = 1;
        repeat (k) lim = lim * 10;
        v = longint'($urandom) % lim;
        if ($urandom_range(0, 1)) v = -v;
        return v[WIDTH-1:0];
      end
      2: begin
        if ($urandom_range(0, 1)) return 32'h8000_0000 + $urandom_range(0, 3);
        return 32'h7FFF_FFFF - $urandom_range(0, 3);
      end
      default: begin
        v = $urandom_range(0, 1000);
        if ($urandom_range(0, 1)) v = -v;
        return v[WIDTH-1:0];
      end
    endcase
  endfunction

  initial begin : stimulus
    logic [WIDTH-1:0] directed[$];
    rst <= 1'b1;
    din_if.valid <= 1'b0;
    din_if.value <= '0;
    hold_sink = 1'b0;
    no_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
                 32'h5555_5555, 32'hAAAA_AAAA, -32'sd9, 32'd4294967295};
    foreach (directed[i]) send_value(directed[i]);

    // drain fully before the random part
    wait_drained();

    repeat (120) send_value(random_value());

    // hold the output off while the input keeps offering numbers
    hold_sink = 1'b1;
    repeat (30) send_value(random_value());

    no_idle = 1'b1;
    repeat (60) send_value(random_value());
    no_idle = 1'b0;

    repeat (140) send_value(random_value());

    wait_drained();
    repeat (100) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[signed_int_to_decimal_ascii] OK");
    end else begin
      $display("[signed_int_to_decimal_ascii] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/s2da_pkg.sv
rtl/s2da_in_if.sv
rtl/s2da_out_if.sv
rtl/s2da_cell.sv
rtl/s2da_row.sv
rtl/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_tb.sv
